### rtl/core/ccint_pkg.sv
// Package for the circle pair intersection core.
// Holds widths, the relation code and the structs passed between pipeline parts.
// Depends on nothing.
package ccint_pkg;

  localparam int unsigned D2W = 50;
  localparam int unsigned KW = 52;
  localparam int unsigned QW = 98;
  localparam int unsigned SW = 49;
  localparam int unsigned NW = 80;
  localparam int unsigned DENW = D2W + 1;
  localparam int unsigned REMW = DENW + 1;
  localparam int unsigned QDW = 27;
  localparam int unsigned HIW = NW - QDW;
  localparam int unsigned DIV_STAGES = QDW + 1;
  localparam int unsigned LANES = 4;

  localparam logic signed [24:0] PT_MAX = 25'sh0FFFFFF;
  localparam logic signed [24:0] PT_MIN = 25'sh1000000;

  typedef enum logic [1:0] {
    REL_SEPARATE,
    REL_CONTAINED,
    REL_COINCIDENT,
    REL_INTERSECT
  } relation_e;

  typedef struct packed {
    relation_e              rel;
    logic signed [23:0]     x0;
    logic signed [23:0]     y0;
    logic signed [24:0]     dx;
    logic signed [24:0]     dy;
    logic [D2W-1:0]         d2;
    logic signed [KW-1:0]   k;
  } sqrt_side_t;

  typedef struct packed {
    logic [NW-1:0]          num;
    logic                   neg;
    logic signed [23:0]     base;
  } div_lane_t;

  typedef struct packed {
    logic [QDW-1:0]         quo;
    logic                   ovf;
    logic                   neg;
    logic signed [23:0]     base;
  } div_res_t;

endpackage

### rtl/core/ccint_if.sv
// Valid/ready channel interfaces for circle pairs and intersection results.
// Depends on nothing.
interface ccint_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] first_center_x;
  logic signed [23:0] first_center_y;
  logic [22:0]        first_radius;
  logic signed [23:0] second_center_x;
  logic signed [23:0] second_center_y;
  logic [22:0]        second_radius;

  modport source (
    output valid, first_center_x, first_center_y, first_radius,
    output second_center_x, second_center_y, second_radius,
    input  ready
  );
  modport sink (
    input  valid, first_center_x, first_center_y, first_radius,
    input  second_center_x, second_center_y, second_radius,
    output ready
  );
endinterface

interface ccint_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         relation;
  logic signed [24:0] point_one_x;
  logic signed [24:0] point_one_y;
  logic signed [24:0] point_two_x;
  logic signed [24:0] point_two_y;

  modport source (
    output valid, relation, point_one_x, point_one_y, point_two_x, point_two_y,
    input  ready
  );
  modport sink (
    input  valid, relation, point_one_x, point_one_y, point_two_x, point_two_y,
    output ready
  );
endinterface

### rtl/core/ccint_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on ccint_pkg.
module ccint_sqrt_pipe (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [ccint_pkg::QW-1:0] rad_i,
  input  ccint_pkg::sqrt_side_t side_i,
  output logic                  valid_o,
  output logic [ccint_pkg::SW-1:0] root_o,
  output ccint_pkg::sqrt_side_t side_o
);
  import ccint_pkg::*;

  logic [SW+1:0] rem_q  [SW];
  logic [SW+1:0] rem_d  [SW];
  logic [SW-1:0] root_q [SW];
  logic [SW-1:0] root_d [SW];
  logic [QW-1:0] rad_q  [SW];
  logic [QW-1:0] rad_d  [SW];
  sqrt_side_t    side_q [SW];
  logic [SW-1:0] v_q;

  always_comb begin
    logic [SW+1:0] prem;
    logic [SW-1:0] proot;
    logic [QW-1:0] prad;
    logic [SW+1:0] rsh;
    logic [SW+1:0] trial;
    for (int s = 0; s < SW; s++) begin
      if (s == 0) begin
        prem  = '0;
        proot = '0;
        prad  = rad_i;
      end else begin
        prem  = rem_q[s-1];
        proot = root_q[s-1];
        prad  = rad_q[s-1];
      end
      rsh   = {prem[SW-1:0], prad[QW-1:QW-2]};
      trial = {proot, 2'b01};
      if (rsh >= trial) begin
        rem_d[s]  = rsh - trial;
        root_d[s] = {proot[SW-2:0], 1'b1};
      end else begin
        rem_d[s]  = rsh;
        root_d[s] = {proot[SW-2:0], 1'b0};
      end
      rad_d[s] = {prad[QW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[SW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < SW; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        rad_q[s]  <= rad_d[s];
        side_q[s] <= (s == 0) ? side_i : side_q[s-1];
      end
    end
  end

  assign valid_o = v_q[SW-1];
  assign root_o  = root_q[SW-1];
  assign side_o  = side_q[SW-1];

  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[SW-1] |-> rem_q[SW-1] <= {1'b0, root_q[SW-1], 1'b0})
    else $error("square root remainder exceeds twice the root");

endmodule

### rtl/core/ccint_div_pipe.sv
// Pipelined restoring divider for the four point lanes, one quotient bit per stage.
// Depends on ccint_pkg.
module ccint_div_pipe (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  ccint_pkg::relation_e     rel_i,
  input  logic [ccint_pkg::D2W-1:0] d2_i,
  input  ccint_pkg::div_lane_t     lanes_i [ccint_pkg::LANES],
  output logic                     valid_o,
  output ccint_pkg::relation_e     rel_o,
  output ccint_pkg::div_res_t      res_o [ccint_pkg::LANES]
);
  import ccint_pkg::*;

  logic [DIV_STAGES-1:0] v_q;
  relation_e             rel_q  [DIV_STAGES];
  logic [DENW-1:0]       den_q  [DIV_STAGES];
  logic [REMW-1:0]       rem_q  [DIV_STAGES][LANES];
  logic [REMW-1:0]       rem_d  [DIV_STAGES][LANES];
  logic [QDW-1:0]        low_q  [DIV_STAGES][LANES];
  logic [QDW-1:0]        low_d  [DIV_STAGES][LANES];
  logic [QDW-1:0]        quo_q  [DIV_STAGES][LANES];
  logic [QDW-1:0]        quo_d  [DIV_STAGES][LANES];
  logic                  ovf_q  [DIV_STAGES][LANES];
  logic                  ovf_d  [DIV_STAGES][LANES];
  logic                  neg_q  [DIV_STAGES][LANES];
  logic signed [23:0]    base_q [DIV_STAGES][LANES];
  logic [DENW-1:0]       den_in;

  assign den_in = {d2_i, 1'b0};

  always_comb begin
    logic [HIW-1:0]  hi;
    logic [REMW-1:0] rsh;
    logic [REMW-1:0] dext;
    logic            ge;
    for (int l = 0; l < LANES; l++) begin
      hi = lanes_i[l].num[NW-1:QDW];
      ovf_d[0][l] = hi >= HIW'(den_in);
      rem_d[0][l] = hi[REMW-1:0];
      low_d[0][l] = lanes_i[l].num[QDW-1:0];
      quo_d[0][l] = '0;
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      for (int l = 0; l < LANES; l++) begin
        rsh  = {rem_q[s-1][l][REMW-2:0], low_q[s-1][l][QDW-1]};
        dext = {1'b0, den_q[s-1]};
        ge   = rsh >= dext;
        rem_d[s][l] = ge ? rsh - dext : rsh;
        low_d[s][l] = {low_q[s-1][l][QDW-2:0], 1'b0};
        quo_d[s][l] = {quo_q[s-1][l][QDW-2:0], ge};
        ovf_d[s][l] = ovf_q[s-1][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DIV_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rel_q[s] <= (s == 0) ? rel_i : rel_q[s-1];
        den_q[s] <= (s == 0) ? den_in : den_q[s-1];
        for (int l = 0; l < LANES; l++) begin
          rem_q[s][l]  <= rem_d[s][l];
          low_q[s][l]  <= low_d[s][l];
          quo_q[s][l]  <= quo_d[s][l];
          ovf_q[s][l]  <= ovf_d[s][l];
          neg_q[s][l]  <= (s == 0) ? lanes_i[l].neg : neg_q[s-1][l];
          base_q[s][l] <= (s == 0) ? lanes_i[l].base : base_q[s-1][l];
        end
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign rel_o   = rel_q[DIV_STAGES-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      res_o[l].quo  = quo_q[DIV_STAGES-1][l];
      res_o[l].ovf  = ovf_q[DIV_STAGES-1][l];
      res_o[l].neg  = neg_q[DIV_STAGES-1][l];
      res_o[l].base = base_q[DIV_STAGES-1][l];
    end
  end

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[DIV_STAGES-1] && !ovf_q[DIV_STAGES-1][0]
      |-> rem_q[DIV_STAGES-1][0] < {1'b0, den_q[DIV_STAGES-1]})
    else $error("divider remainder not below divisor");

endmodule

### rtl/core/circle_circle_intersection_core.sv
// Circle pair classifier and intersection point pipeline.
// It accepts one word per cycle unless the output stalls.
// The depth is set by the 49-stage square root and the 28-stage divider.
// When the output word is not taken, the whole pipeline holds and input ready drops.
// Reset clears all valid bits; payload registers are not reset.
// Depends on ccint_pkg, ccint_if, ccint_sqrt_pipe and ccint_div_pipe.
module circle_circle_intersection_core (
  input  logic clk_i,
  input  logic rst_ni,
  ccint_in_if.sink    in_i,
  ccint_out_if.source out_o
);
  import ccint_pkg::*;

  logic en;
  logic out_valid_q;

  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // Stage 1: differences and the radius sum.
  logic               v1_q;
  logic signed [23:0] x0_1_q, y0_1_q;
  logic [22:0]        r0_1_q, r1_1_q, dif_1_q;
  logic [23:0]        sum_1_q;
  logic signed [24:0] dx_1_q, dy_1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_1_q  <= in_i.first_center_x;
      y0_1_q  <= in_i.first_center_y;
      r0_1_q  <= in_i.first_radius;
      r1_1_q  <= in_i.second_radius;
      dx_1_q  <= 25'(in_i.second_center_x) - 25'(in_i.first_center_x);
      dy_1_q  <= 25'(in_i.second_center_y) - 25'(in_i.first_center_y);
      sum_1_q <= {1'b0, in_i.first_radius} + {1'b0, in_i.second_radius};
      dif_1_q <= (in_i.first_radius >= in_i.second_radius)
               ? in_i.first_radius - in_i.second_radius
               : in_i.second_radius - in_i.first_radius;
    end
  end

  // Stage 2: squares.
  logic               v2_q;
  logic signed [23:0] x0_2_q, y0_2_q;
  logic signed [24:0] dx_2_q, dy_2_q;
  logic [48:0]        dx2_2_q, dy2_2_q;
  logic [47:0]        sum2_2_q;
  logic [45:0]        dif2_2_q, r0sq_2_q, r1sq_2_q;
  logic               req_2_q;
  logic signed [49:0] dxp, dyp;

  assign dxp = dx_1_q * dx_1_q;
  assign dyp = dy_1_q * dy_1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_2_q   <= x0_1_q;
      y0_2_q   <= y0_1_q;
      dx_2_q   <= dx_1_q;
      dy_2_q   <= dy_1_q;
      dx2_2_q  <= dxp[48:0];
      dy2_2_q  <= dyp[48:0];
      sum2_2_q <= sum_1_q * sum_1_q;
      dif2_2_q <= dif_1_q * dif_1_q;
      r0sq_2_q <= r0_1_q * r0_1_q;
      r1sq_2_q <= r1_1_q * r1_1_q;
      req_2_q  <= r0_1_q == r1_1_q;
    end
  end

  // Stage 3: squared distance.
  logic               v3_q;
  logic signed [23:0] x0_3_q, y0_3_q;
  logic signed [24:0] dx_3_q, dy_3_q;
  logic [D2W-1:0]     d2_3_q;
  logic signed [46:0] rr_3_q;
  logic [47:0]        sum2_3_q;
  logic [45:0]        dif2_3_q;
  logic               req_3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_3_q   <= x0_2_q;
      y0_3_q   <= y0_2_q;
      dx_3_q   <= dx_2_q;
      dy_3_q   <= dy_2_q;
      d2_3_q   <= {1'b0, dx2_2_q} + {1'b0, dy2_2_q};
      rr_3_q   <= $signed({1'b0, r0sq_2_q}) - $signed({1'b0, r1sq_2_q});
      sum2_3_q <= sum2_2_q;
      dif2_3_q <= dif2_2_q;
      req_3_q  <= req_2_q;
    end
  end

  // Stage 4: classification and the two factors of the radicand.
  logic           v4_q;
  sqrt_side_t     side_4_q, side_4_d;
  logic [48:0]    qa_4_q, qb_4_q;
  logic [D2W-1:0] qa_full, qb_full;

  always_comb begin
    side_4_d.x0 = x0_3_q;
    side_4_d.y0 = y0_3_q;
    side_4_d.dx = dx_3_q;
    side_4_d.dy = dy_3_q;
    side_4_d.d2 = d2_3_q;
    side_4_d.k  = KW'(rr_3_q) + $signed({2'b00, d2_3_q});
    priority if (d2_3_q > {2'b00, sum2_3_q}) begin
      side_4_d.rel = REL_SEPARATE;
    end else if (d2_3_q < {4'b0000, dif2_3_q}) begin
      side_4_d.rel = REL_CONTAINED;
    end else if (d2_3_q == '0 && req_3_q) begin
      side_4_d.rel = REL_COINCIDENT;
    end else begin
      side_4_d.rel = REL_INTERSECT;
    end
  end

  assign qa_full = {2'b00, sum2_3_q} - d2_3_q;
  assign qb_full = d2_3_q - {4'b0000, dif2_3_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_4_q <= side_4_d;
      qa_4_q   <= qa_full[48:0];
      qb_4_q   <= qb_full[48:0];
    end
  end

  // Stage 5: partial products of the radicand.
  logic        v5_q;
  sqrt_side_t  side_5_q;
  logic [49:0] pp_ll_q;
  logic [48:0] pp_lh_q, pp_hl_q;
  logic [47:0] pp_hh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_5_q <= side_4_q;
      pp_ll_q  <= qa_4_q[24:0] * qb_4_q[24:0];
      pp_lh_q  <= qa_4_q[24:0] * qb_4_q[48:25];
      pp_hl_q  <= qa_4_q[48:25] * qb_4_q[24:0];
      pp_hh_q  <= qa_4_q[48:25] * qb_4_q[48:25];
    end
  end

  // Stage 6: radicand.
  logic          v6_q;
  sqrt_side_t    side_6_q;
  logic [QW-1:0] rad_6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_6_q <= side_5_q;
      rad_6_q  <= QW'(pp_ll_q) + (QW'(pp_lh_q) << 25) + (QW'(pp_hl_q) << 25)
                + (QW'(pp_hh_q) << 50);
    end
  end

  logic          sq_v;
  logic [SW-1:0] sq_root;
  sqrt_side_t    sq_side;

  ccint_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .rad_i   (rad_6_q),
    .side_i  (side_6_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Stage M1: split products of K and S with the differences.
  logic               vm1_q;
  sqrt_side_t         side_m1_q;
  logic signed [51:0] kl_dx_q, kl_dy_q, sl_dx_q, sl_dy_q;
  logic signed [50:0] kh_dx_q, kh_dy_q;
  logic signed [48:0] sh_dx_q, sh_dy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_m1_q <= sq_side;
      kl_dx_q   <= $signed({1'b0, sq_side.k[25:0]}) * sq_side.dx;
      kl_dy_q   <= $signed({1'b0, sq_side.k[25:0]}) * sq_side.dy;
      kh_dx_q   <= $signed(sq_side.k[KW-1:26]) * sq_side.dx;
      kh_dy_q   <= $signed(sq_side.k[KW-1:26]) * sq_side.dy;
      sl_dx_q   <= $signed({1'b0, sq_root[25:0]}) * sq_side.dx;
      sl_dy_q   <= $signed({1'b0, sq_root[25:0]}) * sq_side.dy;
      sh_dx_q   <= $signed({1'b0, sq_root[SW-1:26]}) * sq_side.dx;
      sh_dy_q   <= $signed({1'b0, sq_root[SW-1:26]}) * sq_side.dy;
    end
  end

  // Stage M2: full products.
  logic               vm2_q;
  sqrt_side_t         side_m2_q;
  logic signed [NW-1:0] kdx_q, kdy_q, sdx_q, sdy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_m2_q <= side_m1_q;
      kdx_q <= (NW'(kh_dx_q) <<< 26) + NW'(kl_dx_q);
      kdy_q <= (NW'(kh_dy_q) <<< 26) + NW'(kl_dy_q);
      sdx_q <= (NW'(sh_dx_q) <<< 26) + NW'(sl_dx_q);
      sdy_q <= (NW'(sh_dy_q) <<< 26) + NW'(sl_dy_q);
    end
  end

  // Stage M3: numerators of the four coordinate offsets.
  logic                 vm3_q;
  sqrt_side_t           side_m3_q;
  logic signed [NW-1:0] n_q [LANES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_m3_q <= side_m2_q;
      n_q[0] <= kdx_q + sdy_q;
      n_q[1] <= kdy_q - sdx_q;
      n_q[2] <= kdx_q - sdy_q;
      n_q[3] <= kdy_q + sdx_q;
    end
  end

  // Stage M4: magnitude plus half the divisor, for rounding half away from zero.
  logic       vm4_q;
  relation_e  rel_m4_q;
  logic [D2W-1:0] d2_m4_q;
  div_lane_t  lanes_m4_q [LANES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rel_m4_q <= side_m3_q.rel;
      d2_m4_q  <= side_m3_q.d2;
      for (int l = 0; l < LANES; l++) begin
        lanes_m4_q[l].neg  <= n_q[l][NW-1];
        lanes_m4_q[l].num  <= n_q[l][NW-1] ? NW'(side_m3_q.d2) - $unsigned(n_q[l])
                                           : $unsigned(n_q[l]) + NW'(side_m3_q.d2);
        lanes_m4_q[l].base <= l[0] ? side_m3_q.y0 : side_m3_q.x0;
      end
    end
  end

  logic      dv_v;
  relation_e dv_rel;
  div_res_t  dv_res [LANES];

  ccint_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vm4_q),
    .rel_i   (rel_m4_q),
    .d2_i    (d2_m4_q),
    .lanes_i (lanes_m4_q),
    .valid_o (dv_v),
    .rel_o   (dv_rel),
    .res_o   (dv_res)
  );

  // Output register: add to the center, saturate, zero unless intersecting.
  relation_e          rel_q;
  logic signed [24:0] pt_q [LANES];
  logic signed [24:0] pt_d [LANES];

  always_comb begin
    logic signed [28:0] qv;
    logic signed [28:0] sumv;
    for (int l = 0; l < LANES; l++) begin
      qv   = $signed({2'b00, dv_res[l].quo});
      sumv = 29'(dv_res[l].base) + (dv_res[l].neg ? -qv : qv);
      if (dv_rel != REL_INTERSECT) begin
        pt_d[l] = '0;
      end else if (dv_res[l].ovf) begin
        pt_d[l] = dv_res[l].neg ? PT_MIN : PT_MAX;
      end else if (sumv > 29'(PT_MAX)) begin
        pt_d[l] = PT_MAX;
      end else if (sumv < 29'(PT_MIN)) begin
        pt_d[l] = PT_MIN;
      end else begin
        pt_d[l] = sumv[24:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rel_q <= dv_rel;
      for (int l = 0; l < LANES; l++) begin
        pt_q[l] <= pt_d[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      vm1_q       <= 1'b0;
      vm2_q       <= 1'b0;
      vm3_q       <= 1'b0;
      vm4_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      vm1_q       <= sq_v;
      vm2_q       <= vm1_q;
      vm3_q       <= vm2_q;
      vm4_q       <= vm3_q;
      out_valid_q <= dv_v;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.relation    = rel_q;
  assign out_o.point_one_x = pt_q[0];
  assign out_o.point_one_y = pt_q[1];
  assign out_o.point_two_x = pt_q[2];
  assign out_o.point_two_y = pt_q[3];

  a_intersect_nonzero_d2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && side_4_q.rel == REL_INTERSECT |-> side_4_q.d2 != '0)
    else $error("intersecting pair with zero distance");

  a_points_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rel_q != REL_INTERSECT
      |-> pt_q[0] == '0 && pt_q[1] == '0 && pt_q[2] == '0 && pt_q[3] == '0)
    else $error("points not zero for a non-intersecting pair");

endmodule

### sim/circle_pair_checker.sv
// Checker for the circle pair intersection core: watches both channels,
// predicts each result word and compares it as a whole word.
// Depends on ccint_pkg and ccint_if.
module circle_pair_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ccint_in_if         in_w,
  ccint_out_if        out_w,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import ccint_pkg::*;

  typedef logic signed [127:0] big_t;

  typedef struct packed {
    relation_e          rel;
    logic signed [24:0] p1x;
    logic signed [24:0] p1y;
    logic signed [24:0] p2x;
    logic signed [24:0] p2y;
  } crossing_t;

  crossing_t crossings_due[$];
  int unsigned errors;

  assign errors_o  = errors;
  assign pending_o = crossings_due.size();

  function automatic big_t root_floor(big_t q);
    big_t root;
    big_t trial;
    root = 0;
    for (int i = 55; i >= 0; i--) begin
      trial = root | (big_t'(1) <<< i);
      if (trial * trial <= q) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [24:0] place(longint c, big_t k, big_t u, big_t s,
                                               big_t v, big_t d2);
    big_t n;
    big_t m;
    big_t q;
    longint p;
    n = k * u + s * v;
    m = (n < 0) ? -n : n;
    q = (m + d2) / (d2 * 2);
    if (q > (big_t'(1) <<< 40)) q = big_t'(1) <<< 40;
    p = (n < 0) ? c - longint'(q) : c + longint'(q);
    if (p > 16777215) p = 16777215;
    if (p < -16777216) p = -16777216;
    return p[24:0];
  endfunction

  function automatic crossing_t cross_circles(longint x0, longint y0, longint r0,
                                              longint x1, longint y1, longint r1);
    crossing_t res;
    longint dx;
    longint dy;
    longint d2;
    longint sum2;
    longint dif2;
    big_t k;
    big_t s;
    res = '0;
    dx = x1 - x0;
    dy = y1 - y0;
    d2 = dx * dx + dy * dy;
    sum2 = (r0 + r1) * (r0 + r1);
    dif2 = (r0 - r1) * (r0 - r1);
    if (d2 > sum2) res.rel = REL_SEPARATE;
    else if (d2 < dif2) res.rel = REL_CONTAINED;
    else if (d2 == 0 && r0 == r1) res.rel = REL_COINCIDENT;
    else begin
      res.rel = REL_INTERSECT;
      k = big_t'(r0 * r0 - r1 * r1 + d2);
      s = root_floor(big_t'(sum2 - d2) * big_t'(d2 - dif2));
      res.p1x = place(x0, k, big_t'(dx), s, big_t'(dy), big_t'(d2));
      res.p1y = place(y0, k, big_t'(dy), -s, big_t'(dx), big_t'(d2));
      res.p2x = place(x0, k, big_t'(dx), -s, big_t'(dy), big_t'(d2));
      res.p2y = place(y0, k, big_t'(dy), s, big_t'(dx), big_t'(d2));
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    crossing_t want;
    crossing_t got;
    if (!rst_ni) begin
      errors <= 0;
    end else begin
      if (in_w.valid && in_w.ready) begin
        crossings_due.push_back(cross_circles(
          longint'(in_w.first_center_x), longint'(in_w.first_center_y),
          longint'({1'b0, in_w.first_radius}),
          longint'(in_w.second_center_x), longint'(in_w.second_center_y),
          longint'({1'b0, in_w.second_radius})));
      end
      if (out_w.valid && out_w.ready) begin
        got.rel = relation_e'(out_w.relation);
        got.p1x = out_w.point_one_x;
        got.p1y = out_w.point_one_y;
        got.p2x = out_w.point_two_x;
        got.p2y = out_w.point_two_y;
        if (crossings_due.size() == 0) begin
          if (errors < 10) $display("unexpected result word %p", got);
          errors <= errors + 1;
        end else begin
          want = crossings_due.pop_front();
          if (got !== want) begin
            if (errors < 10) $display("mismatch: expected %p, got %p", want, got);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

### sim/testbench.sv
// Top of the circle pair intersection testbench: clock, reset, stimulus
// and verdict; prediction and comparison live in circle_pair_checker.
// Depends on ccint_pkg, ccint_if, circle_circle_intersection_core and the checker.
module testbench;
  logic clk_i;
  logic rst_ni;
  int unsigned errors;
  int unsigned pending;
  int unsigned cycles;
  int unsigned sent;

  ccint_in_if  in_w ();
  ccint_out_if out_w ();

  circle_circle_intersection_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  circle_pair_checker check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_w      (in_w),
    .out_w     (out_w),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic bit calm();
    return sent >= 600 && sent < 900;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_w.ready <= calm() || ($urandom_range(0, 99) >= 13);
    if (cycles > 200000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_pair(int x0, int y0, int r0, int x1, int y1, int r1);
    while (!calm() && $urandom_range(0, 99) < 13) begin
      in_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_w.valid           <= 1'b1;
    in_w.first_center_x  <= x0[23:0];
    in_w.first_center_y  <= y0[23:0];
    in_w.first_radius    <= r0[22:0];
    in_w.second_center_x <= x1[23:0];
    in_w.second_center_y <= y1[23:0];
    in_w.second_radius   <= r1[22:0];
    do @(posedge clk_i); while (!in_w.ready);
    sent++;
  endtask

  task automatic send_crossing();
    int sc;
    int x0;
    int y0;
    int dx;
    int dy;
    int r0;
    int r1;
    int lo;
    int hi;
    real d;
    sc = $urandom_range(2, 21);
    x0 = $urandom_range(0, 2 ** 24 - 1) - 2 ** 23;
    y0 = $urandom_range(0, 2 ** 24 - 1) - 2 ** 23;
    dx = $urandom_range(0, 2 ** (sc + 1)) - 2 ** sc;
    dy = $urandom_range(0, 2 ** (sc + 1)) - 2 ** sc;
    x0 = (x0 + dx > 8388607 || x0 + dx < -8388608) ? -dx / 2 : x0;
    y0 = (y0 + dy > 8388607 || y0 + dy < -8388608) ? -dy / 2 : y0;
    d = $sqrt(real'(dx) * dx + real'(dy) * dy);
    r0 = $urandom_range(0, 2 ** (sc + 1));
    lo = int'(d) - r0;
    lo = (lo < 0) ? -lo : lo;
    hi = int'(d) + r0;
    if (hi > 8388607) hi = 8388607;
    if (lo > hi) lo = hi;
    case ($urandom_range(0, 5))
      0: r1 = lo;
      1: r1 = hi;
      default: r1 = $urandom_range(lo, hi);
    endcase
    send_pair(x0, y0, r0, x0 + dx, y0 + dy, r1);
  endtask

  initial begin
    rst_ni = 1'b0;
    cycles = 0;
    sent = 0;
    in_w.valid = 1'b0;
    in_w.first_center_x = '0;
    in_w.first_center_y = '0;
    in_w.first_radius = '0;
    in_w.second_center_x = '0;
    in_w.second_center_y = '0;
    in_w.second_radius = '0;
    out_w.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pair(0, 0, 2560, 0, 0, 2560);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(0, 0, 1024, 2560, 0, 1536);
    send_pair(0, 0, 2560, 1024, 0, 1536);
    send_pair(0, 0, 2560, 256, 0, 512);
    send_pair(0, 0, 256, 5120, 0, 256);
    send_pair(0, 0, 2560, 1536, 1024, 2048);
    send_pair(-1000, 300, 700, 200, -900, 1200);
    send_pair(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607);
    send_pair(8388607, 8388607, 8388607, -8388608, -8388608, 8388607);
    send_pair(-8388608, 8388607, 8388607, 8388607, -8388608, 8388607);
    send_pair(8388607, 0, 8388607, 8388607, 0, 0);
    send_pair(-8388608, 0, 8388607, 8388607, 0, 8388607);
    send_pair(8388607, 8388607, 8388607, 8388607, 8388606, 8388607);
    send_pair(-8388608, -8388608, 1, -8388607, -8388608, 1);
    send_pair(0, 0, 8388607, 0, 1, 0);
    send_pair(0, 0, 0, 3, 4, 5);
    send_pair(100, 100, 5, 100, 100, 3);
    send_pair(0, 0, 3, 0, 0, 5);
    send_pair(-8388608, -8388608, 0, 8388607, 8388607, 0);

    repeat (1750) begin
      if ($urandom_range(0, 99) < 75) send_crossing();
      else send_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    in_w.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
